// ===== hw/rtl/necir_pkg.sv =====
// Shared types and constants of the NEC IR frame decoder.
// No dependencies; every other file of the decoder imports this package.
`timescale 1ns / 1ps

package necir_pkg;

	localparam int DEFAULT_STAMP_BITS = 16;
	localparam int DEFAULT_QUEUE_DEPTH = 4;

	localparam int TIMESTAMP_BITS = 16;
	localparam int UNIT_BITS = 16;
	localparam int TOL_BITS = 7;
	localparam int WORD_BITS = 32;
	localparam int PHASE_BITS = 6;

	localparam int CFG_INDEX_BITS = 4;
	localparam int CFG_DATA_BITS = 16;
	localparam logic [CFG_INDEX_BITS-1:0] CFG_UNIT = 4'd0;
	localparam logic [CFG_INDEX_BITS-1:0] CFG_TOL = 4'd1;

	localparam logic [UNIT_BITS-1:0] UNIT_RESET = 16'd280;
	localparam logic [TOL_BITS-1:0] TOL_RESET = 7'd20;
	localparam logic [TOL_BITS-1:0] TOL_MAX = 7'd99;
	localparam logic [7:0] PERCENT_FULL = 8'd100;

	localparam int NUM_WIN = 5;
	localparam int NUM_BOUNDS = 2 * NUM_WIN;
	localparam int BOUND_IDX_BITS = 4;
	localparam logic [2:0] WIN_1 = 3'd0;
	localparam logic [2:0] WIN_3 = 3'd1;
	localparam logic [2:0] WIN_4 = 3'd2;
	localparam logic [2:0] WIN_8 = 3'd3;
	localparam logic [2:0] WIN_16 = 3'd4;

	// bound = (unit * multiple * percent + ROUND_BIAS) / 1600, split as >> 6 then / 25
	localparam int SCALED_BITS = 20;
	localparam int PRODUCT_BITS = 28;
	localparam int DIV_SHIFT = 6;
	localparam int QUOT_IN_BITS = PRODUCT_BITS - DIV_SHIFT;
	localparam int RECIP_BITS = 28;
	localparam int RECIP_SHIFT = 32;
	localparam logic [RECIP_BITS-1:0] RECIP_25 = 28'd171798691;
	localparam logic [QUOT_IN_BITS-1:0] DIVISOR = 22'd25;
	localparam logic [PRODUCT_BITS-1:0] ROUND_BIAS = 28'd800;
	localparam int QUOT_BITS = 18;

	typedef logic [PHASE_BITS-1:0] phase_t;
	localparam phase_t PHASE_IDLE = 6'd0;
	localparam phase_t PHASE_START = 6'd1;
	localparam phase_t PHASE_LAST = 6'd34;

	typedef struct packed {
		logic pause;
		logic [NUM_WIN-1:0] hit;
	} cls_t;

endpackage

// ===== hw/rtl/nec_ir_frame_decoder.sv =====
// NEC IR frame decoder top level: one edge item in, one frame word out per frame.
// An accepted edge item passes the queue, then the output register, to its frame word.
// Throughput: one edge item per cycle, none while bounds compute or the queue is full;
// a 4-entry queue decouples front and back. Window bounds are recomputed after reset and
// each unit or tolerance write (4 steps of the shared multiplier for each of 10 bounds).
// Reset (arst_n, asynchronous, active low) clears stamp, phase, collector and queue.
`timescale 1ns / 1ps

module nec_ir_frame_decoder import necir_pkg::*; #(
	parameter int STAMP_BITS = DEFAULT_STAMP_BITS,
	parameter int QUEUE_DEPTH = DEFAULT_QUEUE_DEPTH
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      s_axis_tvalid,
	output logic                      s_axis_tready,
	input  logic [15:0]               s_axis_tdata,  // [15:0] timestamp
	input  logic [0:0]                s_axis_tuser,  // [0] burst_start
	output logic                      m_axis_tvalid,
	input  logic                      m_axis_tready,
	output logic [31:0]               m_axis_tdata,  // [31:0] frame_word
	input  logic                      cfg_valid,
	output logic                      cfg_ready,
	input  logic [CFG_INDEX_BITS-1:0] cfg_index,
	input  logic [CFG_DATA_BITS-1:0]  cfg_data
);

	logic win_busy;
	logic [STAMP_BITS-1:0] bounds [NUM_BOUNDS];
	logic accept;
	cls_t item;
	logic q_full;
	logic q_empty;
	logic q_pop;
	cls_t q_head;

	assign s_axis_tready = !win_busy && !q_full;
	assign accept = s_axis_tvalid && s_axis_tready;

	necir_window_calc #(
		.STAMP_BITS(STAMP_BITS)
	) u_window_calc (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data),
		.busy     (win_busy),
		.bounds   (bounds)
	);

	necir_classify #(
		.STAMP_BITS(STAMP_BITS)
	) u_classify (
		.clk        (clk),
		.arst_n     (arst_n),
		.accept     (accept),
		.timestamp  (s_axis_tdata),
		.burst_start(s_axis_tuser[0]),
		.bounds     (bounds),
		.item       (item)
	);

	necir_queue #(
		.DEPTH(QUEUE_DEPTH)
	) u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (accept),
		.push_item(item),
		.full     (q_full),
		.pop      (q_pop),
		.empty    (q_empty),
		.head     (q_head)
	);

	necir_frame_fsm u_frame_fsm (
		.clk       (clk),
		.arst_n    (arst_n),
		.empty     (q_empty),
		.head      (q_head),
		.pop       (q_pop),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.frame_word(m_axis_tdata)
	);

endmodule

// ===== hw/rtl/necir_window_calc.sv =====
// Configuration registers and duration window bounds of the NEC IR decoder.
// Depends on necir_pkg; one shared multiply-and-reciprocal datapath, four steps a bound.
`timescale 1ns / 1ps

module necir_window_calc import necir_pkg::*; #(
	parameter int STAMP_BITS = DEFAULT_STAMP_BITS
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      cfg_valid,
	output logic                      cfg_ready,
	input  logic [CFG_INDEX_BITS-1:0] cfg_index,
	input  logic [CFG_DATA_BITS-1:0]  cfg_data,
	output logic                      busy,
	output logic [STAMP_BITS-1:0]     bounds [NUM_BOUNDS]
);

	localparam int QX_BITS = QUOT_BITS + STAMP_BITS;

	typedef enum logic [4:0] {
		WC_IDLE  = 5'b00001,
		WC_MUL   = 5'b00010,
		WC_SCALE = 5'b00100,
		WC_RECIP = 5'b01000,
		WC_FIX   = 5'b10000
	} wc_state_t;

	wc_state_t state_q;
	logic [BOUND_IDX_BITS-1:0] idx_q;
	logic [UNIT_BITS-1:0] unit_q;
	logic [TOL_BITS-1:0] tol_q;

	logic [SCALED_BITS-1:0] um_q;
	logic [7:0] pct_q;
	logic [QUOT_IN_BITS-1:0] x_q;
	logic [QUOT_IN_BITS+RECIP_BITS-1:0] prod_q;
	logic [STAMP_BITS-1:0] bounds_q [NUM_BOUNDS];

	logic [2:0] win;
	logic [TOL_BITS-1:0] tol_c;
	logic [SCALED_BITS-1:0] um_d;
	logic [7:0] pct_d;
	logic [PRODUCT_BITS-1:0] n_d;
	logic [QUOT_BITS-1:0] q0;
	logic [QUOT_IN_BITS-1:0] rem;
	logic [QUOT_BITS-1:0] q;
	logic [QX_BITS-1:0] qx;
	logic [STAMP_BITS-1:0] bound_d;

	assign win = idx_q[BOUND_IDX_BITS-1:1];
	assign tol_c = (tol_q > TOL_MAX) ? TOL_MAX : tol_q;

	always_comb begin
		case (win)
			WIN_1:   um_d = SCALED_BITS'(unit_q);
			WIN_3:   um_d = (SCALED_BITS'(unit_q) << 1) + SCALED_BITS'(unit_q);
			WIN_4:   um_d = SCALED_BITS'(unit_q) << 2;
			WIN_8:   um_d = SCALED_BITS'(unit_q) << 3;
			WIN_16:  um_d = SCALED_BITS'(unit_q) << 4;
			default: um_d = '0;
		endcase
	end

	assign pct_d = idx_q[0] ? (PERCENT_FULL + 8'(tol_c)) : (PERCENT_FULL - 8'(tol_c));
	assign n_d = PRODUCT_BITS'(um_q) * PRODUCT_BITS'(pct_q) + ROUND_BIAS;

	// one correction step after the reciprocal estimate
	assign q0 = prod_q[RECIP_SHIFT +: QUOT_BITS];
	assign rem = x_q - QUOT_IN_BITS'(q0) * DIVISOR;
	assign q = (rem >= DIVISOR) ? q0 + QUOT_BITS'(1) : q0;
	assign qx = QX_BITS'(q);
	assign bound_d = ((qx >> STAMP_BITS) != '0) ? '1 : STAMP_BITS'(q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= WC_MUL;
			idx_q <= '0;
			unit_q <= UNIT_RESET;
			tol_q <= TOL_RESET;
		end else begin
			case (state_q)
				WC_IDLE: begin
					if (cfg_valid) begin
						if (cfg_index == CFG_UNIT) begin
							unit_q <= cfg_data[UNIT_BITS-1:0];
							idx_q <= '0;
							state_q <= WC_MUL;
						end else if (cfg_index == CFG_TOL) begin
							tol_q <= cfg_data[TOL_BITS-1:0];
							idx_q <= '0;
							state_q <= WC_MUL;
						end
					end
				end
				WC_MUL:   state_q <= WC_SCALE;
				WC_SCALE: state_q <= WC_RECIP;
				WC_RECIP: state_q <= WC_FIX;
				WC_FIX: begin
					if (idx_q == BOUND_IDX_BITS'(NUM_BOUNDS - 1)) begin
						state_q <= WC_IDLE;
					end else begin
						idx_q <= idx_q + BOUND_IDX_BITS'(1);
						state_q <= WC_MUL;
					end
				end
				default: state_q <= WC_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == WC_MUL) begin
			um_q <= um_d;
			pct_q <= pct_d;
		end
		if (state_q == WC_SCALE) begin
			x_q <= n_d[PRODUCT_BITS-1:DIV_SHIFT];
		end
		if (state_q == WC_RECIP) begin
			prod_q <= (QUOT_IN_BITS+RECIP_BITS)'(x_q) * (QUOT_IN_BITS+RECIP_BITS)'(RECIP_25);
		end
		if (state_q == WC_FIX) begin
			bounds_q[idx_q] <= bound_d;
		end
	end

	assign cfg_ready = (state_q == WC_IDLE);
	assign busy = (state_q != WC_IDLE);
	assign bounds = bounds_q;

endmodule

// ===== hw/rtl/necir_classify.sv =====
// Front end of the NEC IR decoder: edge stamp difference and window tests.
// Depends on necir_pkg and on the bounds from necir_window_calc.
`timescale 1ns / 1ps

module necir_classify import necir_pkg::*; #(
	parameter int STAMP_BITS = DEFAULT_STAMP_BITS
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      accept,
	input  logic [TIMESTAMP_BITS-1:0] timestamp,
	input  logic                      burst_start,
	input  logic [STAMP_BITS-1:0]     bounds [NUM_BOUNDS],
	output cls_t                      item
);

	logic [STAMP_BITS-1:0] prev_stamp_q;
	logic [STAMP_BITS-1:0] stamp;
	logic [STAMP_BITS-1:0] dur;
	logic [NUM_WIN-1:0] hit;

	assign stamp = STAMP_BITS'(timestamp);
	assign dur = stamp - prev_stamp_q;

	always_comb begin
		for (int w = 0; w < NUM_WIN; w++) begin
			hit[w] = (dur > bounds[2*w]) && (dur < bounds[2*w+1]);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_stamp_q <= '0;
		end else if (accept) begin
			prev_stamp_q <= stamp;
		end
	end

	assign item.pause = burst_start;
	assign item.hit = hit;

endmodule

// ===== hw/rtl/necir_queue.sv =====
// Short queue of classified items between front end and frame sequencer.
// Depends on necir_pkg for the item type.
`timescale 1ns / 1ps

module necir_queue import necir_pkg::*; #(
	parameter int DEPTH = DEFAULT_QUEUE_DEPTH
) (
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  cls_t push_item,
	output logic full,
	input  logic pop,
	output logic empty,
	output cls_t head
);

	localparam int IDX_BITS = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_BITS = $clog2(DEPTH + 1);

	cls_t entries_q [DEPTH];
	logic [IDX_BITS-1:0] wr_q;
	logic [IDX_BITS-1:0] rd_q;
	logic [CNT_BITS-1:0] count_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q <= '0;
			rd_q <= '0;
			count_q <= '0;
		end else begin
			if (push) begin
				wr_q <= (wr_q == IDX_BITS'(DEPTH - 1)) ? '0 : wr_q + IDX_BITS'(1);
			end
			if (pop) begin
				rd_q <= (rd_q == IDX_BITS'(DEPTH - 1)) ? '0 : rd_q + IDX_BITS'(1);
			end
			if (push && !pop) begin
				count_q <= count_q + CNT_BITS'(1);
			end else if (pop && !push) begin
				count_q <= count_q - CNT_BITS'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			entries_q[wr_q] <= push_item;
		end
	end

	assign head = entries_q[rd_q];
	assign full = (count_q == CNT_BITS'(DEPTH));
	assign empty = (count_q == '0);

`ifndef NO_ASSERTIONS
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> (count_q < CNT_BITS'(DEPTH)))
		else $error("queue written while full");
	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> (count_q != '0))
		else $error("queue read while empty");
`endif

endmodule

// ===== hw/rtl/necir_frame_fsm.sv =====
// Back end of the NEC IR decoder: frame phase, bit collector and output register.
// Depends on necir_pkg; takes classified items from necir_queue.
`timescale 1ns / 1ps

module necir_frame_fsm import necir_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 empty,
	input  cls_t                 head,
	output logic                 pop,
	output logic                 out_valid,
	input  logic                 out_ready,
	output logic [WORD_BITS-1:0] frame_word
);

	phase_t phase_q;
	logic [WORD_BITS-1:0] coll_q;
	logic out_valid_q;
	logic [WORD_BITS-1:0] out_word_q;

	phase_t phase_d;
	logic [WORD_BITS-1:0] coll_d;
	logic emit;

	assign pop = !empty && (!out_valid_q || out_ready);

	always_comb begin
		phase_d = phase_q;
		coll_d = coll_q;
		emit = 1'b0;
		if (head.pause) begin
			if (phase_q == PHASE_LAST) begin
				phase_d = PHASE_IDLE;
			end else if (phase_q > PHASE_START) begin
				phase_d = phase_q + PHASE_BITS'(1);
				coll_d = {head.hit[WIN_3], coll_q[WORD_BITS-1:1]};
				if (!head.hit[WIN_3] && !head.hit[WIN_1]) begin
					phase_d = PHASE_IDLE;
				end
			end else if (phase_q == PHASE_START) begin
				if (head.hit[WIN_8]) begin
					phase_d = PHASE_START + PHASE_BITS'(1);
					coll_d = '0;
				end else if (head.hit[WIN_4]) begin
					phase_d = PHASE_LAST;
				end else begin
					phase_d = PHASE_IDLE;
				end
			end
		end else begin
			if (phase_q > PHASE_START) begin
				if (!head.hit[WIN_1]) begin
					phase_d = PHASE_IDLE;
				end else if (phase_q == PHASE_LAST) begin
					phase_d = PHASE_IDLE;
					emit = 1'b1;
				end
			end else if (phase_q == PHASE_IDLE) begin
				if (head.hit[WIN_16]) begin
					phase_d = PHASE_START;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PHASE_IDLE;
			coll_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (pop) begin
				phase_q <= phase_d;
				coll_q <= coll_d;
			end
			if (pop && emit) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop && emit) begin
			out_word_q <= coll_q;
		end
	end

	assign out_valid = out_valid_q;
	assign frame_word = out_word_q;

`ifndef NO_ASSERTIONS
	a_phase_range: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q <= PHASE_LAST)
		else $error("frame phase out of range");
	a_emit_word: assert property (@(posedge clk) disable iff (!arst_n)
		(pop && emit) |=> (out_valid_q && (out_word_q == $past(coll_q))))
		else $error("frame word not presented after frame end");
`endif

endmodule

// ===== dv/nec_ir_frame_decoder_tb.sv =====
// Testbench for nec_ir_frame_decoder: sends edge items and checks each frame word against
// its own decoder model, across several window settings and with random idling both sides.
// Depends on necir_pkg and the decoder RTL only.
`timescale 1ns / 1ps

module nec_ir_frame_decoder_tb;
	import necir_pkg::*;

	localparam logic [CFG_INDEX_BITS-1:0] CFG_UNUSED = 4'hF;
	localparam int unsigned WIN_MULT [NUM_WIN] = '{1, 3, 4, 8, 16};
	localparam logic [15:0] STAMP_MAX = 16'hFFFF;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic s_axis_tvalid = 1'b0;
	logic s_axis_tready;
	logic [15:0] s_axis_tdata = '0;  // [15:0] timestamp
	logic [0:0] s_axis_tuser = '0;   // [0] burst_start
	logic m_axis_tvalid;
	logic m_axis_tready = 1'b0;
	logic [31:0] m_axis_tdata;       // [31:0] frame_word
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [CFG_INDEX_BITS-1:0] cfg_index = '0;
	logic [CFG_DATA_BITS-1:0] cfg_data = '0;

	nec_ir_frame_decoder dut (
		.clk(clk),
		.arst_n(arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata),
		.s_axis_tuser(s_axis_tuser),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	// decoder model state
	logic [UNIT_BITS-1:0] unit_reg;
	logic [TOL_BITS-1:0] tol_reg;
	logic [15:0] last_stamp;
	phase_t phase;
	logic [WORD_BITS-1:0] collector;
	logic [15:0] win_lo [NUM_WIN];
	logic [15:0] win_hi [NUM_WIN];

	logic [WORD_BITS-1:0] frame_words_due [$];
	int errors = 0;
	int edges_sent = 0;
	int words_predicted = 0;
	logic [15:0] tx_stamp = '0;
	int err_permille = 0;
	bit src_gaps = 1'b1;
	bit snk_gaps = 1'b1;
	int hold_cycles = 0;

	initial forever #10 clk = ~clk;

	initial begin
		#(20_000_000);
		$display("Simulation FAILED");
		$finish;
	end

	function automatic logic [15:0] scaled_bound(input int unsigned mult, input int unsigned pct);
		longint unsigned v;
		v = (longint'(unit_reg) * mult * pct + 800) / (16 * PERCENT_FULL);
		if (v > STAMP_MAX)
			v = STAMP_MAX;
		return v[15:0];
	endfunction

	function automatic void recompute_windows();
		int unsigned t;
		t = (tol_reg > TOL_MAX) ? TOL_MAX : tol_reg;
		for (int w = 0; w < NUM_WIN; w++) begin
			win_lo[w] = scaled_bound(WIN_MULT[w], PERCENT_FULL - t);
			win_hi[w] = scaled_bound(WIN_MULT[w], PERCENT_FULL + t);
		end
	endfunction

	function automatic bit in_window(input logic [15:0] d, input logic [2:0] w);
		return d > win_lo[w] && d < win_hi[w];
	endfunction

	// advance the model by one edge; queue the frame word if one is due
	function automatic void decode_edge(input logic [15:0] stamp, input logic burst_start);
		logic [15:0] d;
		d = stamp - last_stamp;
		last_stamp = stamp;
		if (burst_start) begin
			if (phase == PHASE_LAST) begin
				phase = PHASE_IDLE;
			end else if (phase > PHASE_START) begin
				phase = phase + 1'b1;
				collector = collector >> 1;
				if (in_window(d, WIN_3))
					collector[WORD_BITS-1] = 1'b1;
				else if (!in_window(d, WIN_1))
					phase = PHASE_IDLE;
			end else if (phase == PHASE_START) begin
				if (in_window(d, WIN_8)) begin
					phase = PHASE_START + 1'b1;
					collector = '0;
				end else if (in_window(d, WIN_4)) begin
					phase = PHASE_LAST;
				end else begin
					phase = PHASE_IDLE;
				end
			end
		end else begin
			if (phase > PHASE_START) begin
				if (!in_window(d, WIN_1)) begin
					phase = PHASE_IDLE;
				end else if (phase == PHASE_LAST) begin
					phase = PHASE_IDLE;
					frame_words_due.push_back(collector);
					words_predicted++;
				end
			end else if (phase == PHASE_IDLE) begin
				if (in_window(d, WIN_16))
					phase = PHASE_START;
			end
		end
	endfunction

	function automatic int gap_len();
		if ($urandom_range(9) == 0)
			return $urandom_range(40, 10);
		return $urandom_range(3, 1);
	endfunction

	// duration inside window w, or anywhere when the window is empty or a fault is injected
	function automatic logic [15:0] pick_in(input logic [2:0] w);
		if ($urandom_range(999) < err_permille || win_hi[w] <= win_lo[w] + 16'd1)
			return 16'($urandom_range(STAMP_MAX, 0));
		return 16'($urandom_range(win_hi[w] - 1, win_lo[w] + 1));
	endfunction

	task automatic send_edge(input logic [15:0] stamp, input logic burst_start);
		if (src_gaps && $urandom_range(1) == 0) begin
			s_axis_tvalid <= 1'b0;
			repeat (gap_len()) @(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= stamp;
		s_axis_tuser <= burst_start;
		do @(posedge clk); while (!s_axis_tready);
		decode_edge(stamp, burst_start);
		tx_stamp = stamp;
		edges_sent++;
	endtask

	task automatic send_dur(input logic [15:0] d, input logic burst_start);
		send_edge(tx_stamp + d, burst_start);
	endtask

	task automatic settle_decoder();
		s_axis_tvalid <= 1'b0;
		while (frame_words_due.size() != 0) @(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	task automatic write_reg(input logic [CFG_INDEX_BITS-1:0] idx,
		input logic [CFG_DATA_BITS-1:0] val);
		settle_decoder();
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		if (idx == CFG_UNIT) begin
			unit_reg = val;
			recompute_windows();
		end else if (idx == CFG_TOL) begin
			tol_reg = val[TOL_BITS-1:0];
			recompute_windows();
		end
		@(posedge clk);
	endtask

	task automatic send_leader();
		send_dur(pick_in(WIN_1), 1'b1);
		send_dur(pick_in(WIN_16), 1'b0);
	endtask

	task automatic send_repeat();
		send_leader();
		send_dur(pick_in(WIN_4), 1'b1);
		send_dur(pick_in(WIN_1), 1'b0);
	endtask

	task automatic send_frame(input int nbits);
		logic [31:0] bits;
		bits = $urandom();
		send_leader();
		send_dur(pick_in(WIN_8), 1'b1);
		for (int i = 0; i < nbits; i++) begin
			send_dur(pick_in(WIN_1), 1'b0);
			send_dur(pick_in(bits[i] ? WIN_3 : WIN_1), 1'b1);
		end
		send_dur(pick_in(WIN_1), 1'b0);
	endtask

	task automatic run_traffic(input int n_edges, input int n_words);
		int stop_edges;
		int stop_words;
		int kind;
		stop_edges = edges_sent + n_edges;
		stop_words = words_predicted + n_words;
		while (edges_sent < stop_edges || words_predicted < stop_words) begin
			kind = $urandom_range(99);
			src_gaps = $urandom_range(3) != 0;
			snk_gaps = $urandom_range(3) != 0;
			err_permille = ($urandom_range(9) == 0) ? 30 : 0;
			if (kind < 35) begin
				send_frame(32);
			end else if (kind < 70) begin
				send_repeat();
			end else if (kind < 85) begin
				err_permille = 40;
				send_frame($urandom_range(31));
			end else begin
				repeat ($urandom_range(6, 1))
					send_dur(16'($urandom_range(STAMP_MAX, 0)), 1'($urandom_range(1)));
			end
		end
		err_permille = 0;
	endtask

	task automatic test_edge_cases();
		// extremes of the stamp, pause while idle, short mark while idle
		send_edge(STAMP_MAX, 1'b1);
		send_edge(16'h0000, 1'b0);
		// leader, stray mark before its pause, then three bits and a bad mark
		send_leader();
		send_dur(pick_in(WIN_1), 1'b0);
		send_dur(pick_in(WIN_8), 1'b1);
		send_dur(pick_in(WIN_1), 1'b0);
		send_dur(pick_in(WIN_3), 1'b1);
		send_dur(pick_in(WIN_1), 1'b0);
		send_dur(pick_in(WIN_1), 1'b1);
		send_dur(pick_in(WIN_1), 1'b0);
		send_dur(pick_in(WIN_3), 1'b1);
		send_dur(16'd0, 1'b0);
		// repeat code returns the bits left by the aborted frame
		send_repeat();
		// a second pause straight after a repeat pause
		send_leader();
		send_dur(pick_in(WIN_4), 1'b1);
		send_dur(pick_in(WIN_1), 1'b1);
		send_frame(32);
	endtask

	task automatic test_default_windows();
		run_traffic(160, 3);
	endtask

	task automatic test_widest_windows();
		write_reg(CFG_UNIT, 16'hFFFF);
		write_reg(CFG_TOL, 16'd99);
		run_traffic(110, 2);
	endtask

	task automatic test_empty_windows();
		write_reg(CFG_UNIT, 16'd1);
		write_reg(CFG_TOL, 16'd0);
		run_traffic(50, 0);
	endtask

	task automatic test_narrow_windows();
		write_reg(CFG_UNIT, 16'd320);
		write_reg(CFG_TOL, 16'd5);
		run_traffic(110, 2);
	endtask

	task automatic test_tolerance_clamp();
		write_reg(CFG_UNIT, 16'd400);
		write_reg(CFG_TOL, 16'd127);
		run_traffic(90, 2);
	endtask

	task automatic test_zero_unit();
		write_reg(CFG_UNIT, 16'd0);
		run_traffic(40, 0);
	endtask

	task automatic test_unknown_register();
		write_reg(CFG_UNIT, 16'd280);
		write_reg(CFG_TOL, 16'd20);
		write_reg(CFG_UNUSED, 16'hFFFF);
		run_traffic(80, 2);
	endtask

	task automatic test_output_backpressure();
		settle_decoder();
		src_gaps = 1'b0;
		hold_cycles = 400;
		repeat (10) send_repeat();
		send_frame(32);
	endtask

	// sink: random stalls, plus one long hold-off on request
	initial begin
		forever begin
			@(posedge clk);
			if (hold_cycles > 0) begin
				m_axis_tready <= 1'b0;
				repeat (hold_cycles) @(posedge clk);
				hold_cycles = 0;
				m_axis_tready <= 1'b1;
			end else if (snk_gaps && $urandom_range(4) == 0) begin
				m_axis_tready <= 1'b0;
				repeat (gap_len()) @(posedge clk);
				m_axis_tready <= 1'b1;
			end else begin
				m_axis_tready <= 1'b1;
			end
		end
	end

	always @(posedge clk) begin
		logic [WORD_BITS-1:0] want;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			if (frame_words_due.size() == 0) begin
				$display("%0t: unexpected frame word: expected none, actual %h", $time,
					m_axis_tdata);
				errors++;
			end else begin
				want = frame_words_due.pop_front();
				if (m_axis_tdata !== want) begin
					$display("%0t: frame_word mismatch: expected %h, actual %h", $time,
						want, m_axis_tdata);
					errors++;
				end
			end
		end
	end

	initial begin
		int waited;
		unit_reg = UNIT_RESET;
		tol_reg = TOL_RESET;
		last_stamp = '0;
		phase = PHASE_IDLE;
		collector = '0;
		recompute_windows();
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_edge_cases();
		test_default_windows();
		test_widest_windows();
		test_empty_windows();
		test_narrow_windows();
		test_tolerance_clamp();
		test_zero_unit();
		test_unknown_register();
		test_output_backpressure();

		s_axis_tvalid <= 1'b0;
		waited = 0;
		while (frame_words_due.size() != 0 && waited < 20000) begin
			@(posedge clk);
			waited++;
		end
		if (frame_words_due.size() != 0) begin
			$display("%0t: %0d frame words never arrived, expected %h first, actual none",
				$time, frame_words_due.size(), frame_words_due[0]);
			errors++;
		end
		repeat (20) @(posedge clk);
		if (errors == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

endmodule

// ===== sim.f =====
hw/rtl/necir_pkg.sv
hw/rtl/necir_window_calc.sv
hw/rtl/necir_classify.sv
hw/rtl/necir_queue.sv
hw/rtl/necir_frame_fsm.sv
hw/rtl/nec_ir_frame_decoder.sv
dv/nec_ir_frame_decoder_tb.sv
